// File: src/dec_pkg.sv
// Package for the directional edge convolution block.
// Holds the payload structs, register indexes, job and line-write types, back-end states.
// No dependencies.
package dec_pkg;

  // Widths of the fixed payload fields.
  localparam int PIX_W   = 8;
  localparam int POSN_W  = 10;
  localparam int CFG_W   = 40;
  localparam int DIM_W   = 11;
  localparam int IDX_W   = 3;
  localparam int KROWS   = 5;

  // Job and line-write fields are sized for the largest supported image.
  localparam int JOB_CW  = 12;
  localparam int JOB_RW  = 13;
  localparam int SLOT_W  = 3;

  // Depth of the job queue between the front and back ends.
  localparam int QDEPTH  = 4;

  // Mid level added to every normalized response.
  localparam int MID_LEVEL = 127;

  // Defaults for the top-level parameters.
  localparam int KSIZE_DEF      = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KROW0  = 3'd2,
    REG_KROW1  = 3'd3,
    REG_KROW2  = 3'd4,
    REG_KROW3  = 3'd5,
    REG_KROW4  = 3'd6
  } reg_idx_t;

  typedef logic [KROWS-1:0][CFG_W-1:0] krows_t;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  up_value;
    logic [PIX_W-1:0]  right_value;
    logic [POSN_W-1:0] out_col;
    logic [POSN_W-1:0] out_row;
    logic              last_in_frame;
  } out_item_t;

  // One result to compute: its column and the input row that caused it.
  typedef struct packed {
    logic [JOB_CW-1:0] col;
    logic [JOB_RW-1:0] row;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [JOB_CW-1:0] col;
    logic [PIX_W-1:0]  data;
  } line_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TAPS,
    B_DRAIN,
    B_DIV,
    B_OUT
  } back_state_t;

  // Signed kernel weight at row r, column c.
  function automatic logic signed [PIX_W-1:0] kweight(input krows_t k,
                                                      input logic [2:0] r,
                                                      input logic [2:0] c);
    return $signed(k[r][{c, 3'b000} +: PIX_W]);
  endfunction

endpackage

// File: src/dec_queue.sv
// Short job queue between the front and back ends.
// Depends on dec_pkg for job_t and QDEPTH.
module dec_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dec_pkg::job_t push_job,
  input  logic          pop,
  output dec_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);
  import dec_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  job_t           entry_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_job = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) wptr_r <= wptr_r + 1'b1;
      if (pop && !empty) rptr_r <= rptr_r + 1'b1;
      if ((push && !full) && !(pop && !empty)) cnt_r <= cnt_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: src/dec_front.sv
// Front end: accepts items, keeps the raster position, writes the line store
// and queues one job per result. Depends on dec_pkg.
module dec_front #(
  parameter int KSIZE      = dec_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH  = dec_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dec_pkg::in_item_t                     in_data,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        img_w,
  input  logic [$clog2(MAX_HEIGHT+KSIZE)-1:0]   img_h,
  input  logic                                  pos_nz,
  input  logic                                  back_taps,
  input  logic                                  q_empty,
  input  logic                                  q_full,
  output logic                                  q_push,
  output dec_pkg::job_t                         q_job,
  output dec_pkg::line_wr_t                     line_wr
);
  import dec_pkg::*;

  localparam int H  = KSIZE / 2;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT+KSIZE);
  localparam int SW = $clog2(KSIZE);

  logic [CW-1:0] c_r, gc_r, ghi_r;
  logic [RW-1:0] r_r, gr_r;
  logic [SW-1:0] slot_r;
  logic          gen_act_r;

  logic          accept, row_end, has_jobs;
  logic [CW-1:0] gen_lo, gen_hi;

  assign in_stall = gen_act_r || !q_empty || back_taps;
  assign accept   = in_valid && !in_stall;
  assign row_end  = (WW'(c_r) >= img_w - 1'b1);
  assign has_jobs = pos_nz && (r_r >= RW'(H)) && ((c_r >= CW'(H)) || row_end);
  assign gen_lo   = (c_r >= CW'(H)) ? c_r - CW'(H) : '0;
  assign gen_hi   = row_end ? c_r : c_r - CW'(H);

  assign q_push    = gen_act_r && !q_full;
  assign q_job.col = JOB_CW'(gc_r);
  assign q_job.row = JOB_RW'(gr_r);

  always_comb begin
    line_wr.en   = accept && (r_r < img_h);
    line_wr.slot = SLOT_W'(slot_r);
    line_wr.col  = JOB_CW'(c_r);
    line_wr.data = in_data.cmd ? '0 : in_data.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r       <= '0;
      r_r       <= '0;
      slot_r    <= '0;
      gen_act_r <= 1'b0;
    end else begin
      if (accept) begin
        if (row_end) begin
          c_r <= '0;
          if ((RW+1)'(r_r) >= (RW+1)'(img_h) + (RW+1)'(H) - 1'b1) begin
            r_r    <= '0;
            slot_r <= '0;
          end else begin
            r_r    <= r_r + 1'b1;
            slot_r <= (slot_r == SW'(KSIZE-1)) ? '0 : slot_r + 1'b1;
          end
        end else begin
          c_r <= c_r + 1'b1;
        end
        gen_act_r <= has_jobs;
      end else if (q_push && (gc_r == ghi_r)) begin
        gen_act_r <= 1'b0;
      end
    end
  end

  // Job range registers: loaded on accept, walked one column per push.
  always_ff @(posedge clk) begin
    if (accept) begin
      gc_r  <= gen_lo;
      ghi_r <= gen_hi;
      gr_r  <= r_r;
    end else if (q_push) begin
      gc_r <= gc_r + 1'b1;
    end
  end

endmodule

// File: src/dec_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing outside this file.
module dec_div #(
  parameter int NW = 21,
  parameter int DW = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW+1);

  logic [CNTW-1:0] cnt_r;
  logic            busy_r, neg_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   q_r;
  logic [DW:0]     trial;
  logic            bit_ok;

  assign trial  = {rem_r, q_r[NW-1]};
  assign bit_ok = (trial >= {1'b0, den});
  assign done   = busy_r && (cnt_r == '0);
  assign quo    = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(NW);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW-1];
      q_r   <= num[NW-1] ? NW'(-num) : NW'(num);
      rem_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= bit_ok ? DW'(trial - {1'b0, den}) : DW'(trial);
      q_r   <= {q_r[NW-2:0], bit_ok};
    end
  end

endmodule

// File: src/dec_back.sv
// Back end: owns the line store, gathers the clamped window one tap a cycle,
// accumulates both responses, divides and holds the result. Depends on dec_pkg, dec_div.
module dec_back #(
  parameter int KSIZE      = dec_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH  = dec_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dec_pkg::line_wr_t                     line_wr,
  input  logic                                  job_valid,
  input  dec_pkg::job_t                         job,
  output logic                                  job_pop,
  output logic                                  back_taps,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        img_w,
  input  logic [$clog2(MAX_HEIGHT+KSIZE)-1:0]   img_h,
  input  logic [8+$clog2(KSIZE*KSIZE)-1:0]      den,
  input  dec_pkg::krows_t                       kern,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dec_pkg::out_item_t                    out_data
);
  import dec_pkg::*;

  localparam int H     = KSIZE / 2;
  localparam int KK    = KSIZE * KSIZE;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int RW    = $clog2(MAX_HEIGHT+KSIZE);
  localparam int SW    = $clog2(KSIZE);
  localparam int TW    = $clog2(KSIZE+1);
  localparam int ACC_W = 17 + $clog2(KK);
  localparam int DENW  = 8 + $clog2(KK);
  localparam int RECIP = (65536 + KSIZE - 1) / KSIZE;

  logic [PIX_W-1:0] mem [KSIZE][MAX_WIDTH];

  back_state_t state_r, state_nxt;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [TW-1:0] ti_r, tj_r, tid_r, tjd_r;
  logic          rd_vld_r;
  logic [PIX_W-1:0] rd_data_r;
  logic signed [ACC_W-1:0] acc_up_r, acc_rt_r;
  out_item_t     out_r;

  logic signed [RW+1:0] t_row;
  logic [RW-1:0]        rr;
  logic [RW+15:0]       rr_prod;
  logic [RW-1:0]        rr_q, rr_rem;
  logic [SW-1:0]        rd_slot;
  logic signed [CW+1:0] t_col;
  logic [CW-1:0]        rd_col;
  logic                 issue;
  logic signed [PIX_W-1:0] w_up, w_rt;
  logic signed [2*PIX_W:0] p_up, p_rt;
  logic                 div_start, dv_done_up, dv_done_rt;
  logic signed [ACC_W-1:0] q_up, q_rt;
  logic [RW-1:0]        orow;

  // Row and column taps: clamp to the frame; the store slot is the row modulo KSIZE.
  always_comb begin
    t_row = $signed((RW+2)'(row_r)) - $signed((RW+2)'(2*H)) + $signed((RW+2)'(tj_r));
    if (t_row < 0) rr = '0;
    else if (t_row >= $signed((RW+2)'(img_h))) rr = img_h - 1'b1;
    else rr = RW'(t_row);
    rr_prod = (RW+16)'(rr) * (RW+16)'(RECIP);
    rr_q    = RW'(rr_prod >> 16);
    rr_rem  = rr - RW'(rr_q * RW'(KSIZE));
    rd_slot = SW'(rr_rem);
    t_col = $signed((CW+2)'(col_r)) + $signed((CW+2)'(ti_r)) - $signed((CW+2)'(H));
    if (t_col < 0) rd_col = '0;
    else if (t_col >= $signed((CW+2)'(img_w))) rd_col = CW'(img_w - 1'b1);
    else rd_col = CW'(t_col);
  end

  assign issue = (state_r == B_TAPS) && (tj_r != TW'(KSIZE));

  always_ff @(posedge clk) begin
    if (line_wr.en) begin
      mem[line_wr.slot[SW-1:0]][line_wr.col[CW-1:0]] <= line_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_slot][rd_col];
  end

  // Weights for the tap whose pixel arrives this cycle.
  assign w_up = kweight(kern, 3'(tjd_r), 3'(tid_r));
  assign w_rt = kweight(kern, 3'(tid_r), 3'(KSIZE-1) - 3'(tjd_r));
  assign p_up = $signed({1'b0, rd_data_r}) * w_up;
  assign p_rt = $signed({1'b0, rd_data_r}) * w_rt;

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    div_start = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = B_TAPS;
        end
      end
      B_TAPS: begin
        if (!issue) state_nxt = B_DRAIN;
      end
      B_DRAIN: begin
        div_start = 1'b1;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (dv_done_up) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_stall) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      col_r    <= CW'(job.col);
      row_r    <= RW'(job.row);
      ti_r     <= '0;
      tj_r     <= '0;
      acc_up_r <= '0;
      acc_rt_r <= '0;
    end else begin
      if (issue) begin
        if (ti_r == TW'(KSIZE-1)) begin
          ti_r <= '0;
          tj_r <= tj_r + 1'b1;
        end else begin
          ti_r <= ti_r + 1'b1;
        end
      end
      if (rd_vld_r) begin
        acc_up_r <= acc_up_r + ACC_W'(p_up);
        acc_rt_r <= acc_rt_r + ACC_W'(p_rt);
      end
    end
    tid_r <= ti_r;
    tjd_r <= tj_r;
  end

  dec_div #(.NW(ACC_W), .DW(DENW)) u_div_up (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_up_r), .den(den),
    .done(dv_done_up), .quo(q_up)
  );

  dec_div #(.NW(ACC_W), .DW(DENW)) u_div_rt (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_rt_r), .den(den),
    .done(dv_done_rt), .quo(q_rt)
  );

  function automatic logic [PIX_W-1:0] sat_level(input logic signed [ACC_W-1:0] q);
    logic signed [ACC_W-1:0] v;
    v = q + ACC_W'(MID_LEVEL);
    if (v < 0) return '0;
    if (v > $signed(ACC_W'(255))) return '1;
    return PIX_W'(v);
  endfunction

  assign orow = row_r - RW'(H);

  always_ff @(posedge clk) begin
    if ((state_r == B_DIV) && dv_done_up) begin
      out_r.up_value      <= sat_level(q_up);
      out_r.right_value   <= sat_level(q_rt);
      out_r.out_col       <= POSN_W'(col_r);
      out_r.out_row       <= POSN_W'(orow);
      out_r.last_in_frame <= (WW'(col_r) == img_w - 1'b1) && (orow == img_h - 1'b1);
    end
  end

  assign out_valid = (state_r == B_OUT);
  assign out_data  = out_r;
  assign back_taps = (state_r == B_TAPS);

  // The front must never write the store while a window is being read.
  a_no_write_in_taps: assert property (@(posedge clk) disable iff (!rst_n)
    line_wr.en |-> (state_r != B_TAPS))
    else $error("line store written during window read");

  a_drain_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DRAIN) |=> (state_r == B_DIV))
    else $error("divide not started after drain");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_done_up == dv_done_rt) && (!dv_done_up || (state_r == B_DIV)))
    else $error("dividers out of step");

endmodule

// File: src/directional_edge_convolution.sv
// Top level of the two-direction edge convolution block.
// Holds the configuration registers; depends on dec_pkg, dec_front, dec_queue, dec_back.
//
//   channel   direction  handshake          payload
//   in_*      input      in_valid/in_stall  in_item_t (cmd, pixel)
//   out_*     output     out_valid/out_stall out_item_t (responses, position, last)
//   cfg_*     input      cfg_we             cfg_index, cfg_data
//
// The back end gathers each result's window one tap per cycle through the single line-store
// read port, then divides in the bit-serial dividers. An item that makes no result does
// not stall the input; an item is taken again once its jobs have left the window read.
// Reset (rst_n low, synchronous) clears counters, queue and state; the line store is not
// cleared. A stalled result holds in the output register while the next item is taken.
module directional_edge_convolution #(
  parameter int KSIZE      = dec_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH  = dec_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dec_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dec_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [dec_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dec_pkg::CFG_W-1:0]     cfg_data
);
  import dec_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int RW   = $clog2(MAX_HEIGHT+KSIZE);
  localparam int XW   = (RW > DIM_W) ? RW + 1 : DIM_W + 1;
  localparam int POSW = 7 + $clog2(KSIZE*KSIZE);
  localparam int DENW = POSW + 1;

  logic [DIM_W-1:0] width_r, height_r;
  krows_t           krow_r;

  logic [WW-1:0]    img_w;
  logic [RW-1:0]    img_h;
  logic [POSW-1:0]  pos;
  logic [DENW-1:0]  den;

  job_t     q_job, head_job;
  line_wr_t line_wr;
  logic     q_push, q_pop, q_empty, q_full, back_taps;

  // Configuration writes land directly; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      krow_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r  <= cfg_data[DIM_W-1:0];
        REG_KROW0:  krow_r[0] <= cfg_data;
        REG_KROW1:  krow_r[1] <= cfg_data;
        REG_KROW2:  krow_r[2] <= cfg_data;
        REG_KROW3:  krow_r[3] <= cfg_data;
        REG_KROW4:  krow_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Image size is used clamped to 1..MAX.
  always_comb begin
    if (width_r == '0) img_w = WW'(1);
    else if (XW'(width_r) > XW'(MAX_WIDTH)) img_w = WW'(MAX_WIDTH);
    else img_w = WW'(width_r);
    if (height_r == '0) img_h = RW'(1);
    else if (XW'(height_r) > XW'(MAX_HEIGHT)) img_h = RW'(MAX_HEIGHT);
    else img_h = RW'(height_r);
  end

  // Sum of the positive weights; the divisor is twice that sum.
  always_comb begin
    logic signed [PIX_W-1:0] k;
    pos = '0;
    for (int j = 0; j < KSIZE; j++) begin
      for (int i = 0; i < KSIZE; i++) begin
        k = kweight(krow_r, 3'(j), 3'(i));
        if (k > 0) pos = pos + POSW'(k);
      end
    end
  end

  assign den = {pos, 1'b0};

  dec_front #(.KSIZE(KSIZE), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .img_w(img_w), .img_h(img_h), .pos_nz(pos != '0), .back_taps(back_taps),
    .q_empty(q_empty), .q_full(q_full), .q_push(q_push), .q_job(q_job), .line_wr(line_wr)
  );

  dec_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_job), .pop(q_pop),
    .head_job(head_job), .empty(q_empty), .full(q_full)
  );

  dec_back #(.KSIZE(KSIZE), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .line_wr(line_wr), .job_valid(!q_empty), .job(head_job),
    .job_pop(q_pop), .back_taps(back_taps), .img_w(img_w), .img_h(img_h), .den(den),
    .kern(krow_r), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// File: tb/sv/tb.sv
// Testbench for the directional edge convolution block: predicts every result from the
// register settings and the pixel stream, and compares each whole result. Depends on dec_pkg and the top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dec_pkg::*;

  localparam int KS = KSIZE_DEF;
  localparam int HK = KS / 2;
  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int MAXH = MAX_HEIGHT_DEF;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  directional_edge_convolution dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's registers and state, kept by the predictor.
  int unsigned pred_width, pred_height;
  logic [CFG_W-1:0] pred_krow [KROWS];
  logic [PIX_W-1:0] pred_lines [KS][MAXW];
  int unsigned pred_col, pred_row;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int unsigned mismatches = 0;
  bit failed = 1'b0;
  bit quiet_tail = 1'b0;   // no idling on either side near the end of the run
  bit hold_out = 1'b0;     // the long receiver hold-off
  int unsigned cycle_count = 0;

  function automatic int kw(int r, int c);
    logic signed [7:0] b;
    b = pred_krow[r][8*c +: 8];
    return int'(b);
  endfunction

  function automatic int clampi(int v, int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic logic [7:0] normalize(int s, int p);
    int v;
    v = s / (p * 2) + MID_LEVEL;   // SystemVerilog division truncates toward zero
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Computes the result for the pixel at (col,row) from the shadow line store.
  function automatic out_item_t window_result(int col, int row, int w, int h, int p);
    out_item_t o;
    int up, rt, px;
    up = 0;
    rt = 0;
    for (int j = 0; j < KS; j++)
      for (int i = 0; i < KS; i++) begin
        px = int'(pred_lines[clampi(row + j - HK, h) % KS][clampi(col + i - HK, w)]);
        up += px * kw(j, i);
        rt += px * kw(i, KS - 1 - j);
      end
    o.up_value = normalize(up, p);
    o.right_value = normalize(rt, p);
    o.out_col = col[POSN_W-1:0];
    o.out_row = row[POSN_W-1:0];
    o.last_in_frame = (col == w - 1 && row == h - 1);
    return o;
  endfunction

  // Advances the shadow state by one accepted request and queues its results.
  task automatic predict_edges(input in_item_t it);
    int w, h, c, r, p, k;
    bit row_end;
    w = pred_width;
    h = pred_height;
    c = pred_col;
    r = pred_row;
    p = 0;
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    if (h < 1) h = 1;
    if (h > MAXH) h = MAXH;
    if (r < h && c < MAXW) pred_lines[r % KS][c] = it.cmd ? 8'd0 : it.pixel;
    for (int j = 0; j < KS; j++)
      for (int i = 0; i < KS; i++) begin
        k = kw(j, i);
        if (k > 0) p += k;
      end
    row_end = (c >= w - 1);
    if (p > 0 && r >= HK) begin
      if (c >= HK) expected_results.push_back(window_result(c - HK, r - HK, w, h, p));
      if (row_end)
        for (int q = (c >= HK) ? c - HK + 1 : 0; q <= c; q++)
          expected_results.push_back(window_result(q, r - HK, w, h, p));
    end
    if (row_end) begin
      pred_col = 0;
      pred_row = (r >= h + HK - 1) ? 0 : r + 1;
    end else begin
      pred_col = c + 1;
    end
  endtask

  // Driver: offers the oldest pending request, with random bursts of idle cycles.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_edges(in_data);
        void'(pending_items.pop_front());
        if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 9);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if ((in_valid && !in_stall) ? pending_items.size() > 0 : pending_items.size() > 0)
        begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expected one and drives out_stall.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failed = 1'b1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
          mismatches++;
        end else begin
          if (out_data !== expected_results[0]) begin
            failed = 1'b1;
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", expected_results[0], out_data);
            mismatches++;
          end
          void'(expected_results.pop_front());
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet_tail && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
      out_stall <= hold_out || (stall_left > 0);
    end
  end

  // Configuration writes happen only while the block is idle.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) pred_width = v[DIM_W-1:0];
    else if (idx == REG_HEIGHT) pred_height = v[DIM_W-1:0];
    else pred_krow[idx - REG_KROW0] = v;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // Items that make no result send no job to the back end.
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_krow();
    return {$urandom(), 8'($urandom())};
  endfunction

  // Queues whole frames: (height + HK) rows of width items, flush items on padding rows; noisy flips some cmds.
  task automatic queue_frames(input int w, input int h, input int frames, input bit noisy);
    in_item_t it;
    for (int f = 0; f < frames; f++)
      for (int r = 0; r < h + HK; r++)
        for (int c = 0; c < w; c++) begin
          it.pixel = $urandom();
          it.cmd = (r >= h);
          if (noisy && $urandom_range(0, 15) == 0) it.cmd = ~it.cmd;
          pending_items.push_back(it);
        end
  endtask

  task automatic set_frame(input int w, input int h);
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
  endtask

  initial begin
    int w, h;
    pred_width = 640;
    pred_height = 480;
    pred_col = 0;
    pred_row = 0;
    for (int i = 0; i < KROWS; i++) pred_krow[i] = '0;
    for (int i = 0; i < KS; i++) for (int j = 0; j < MAXW; j++) pred_lines[i][j] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a kernel with extreme weights, pixels at 0 and 255.
    write_reg(REG_KROW0, 40'hFF_FF_00_80_7F ^ 40'hFF_FF_00_00_00);
    write_reg(REG_KROW1, 40'h00_00_7F_00_81);
    write_reg(REG_KROW2, 40'h00_00_01_00_FF);
    write_reg(REG_KROW3, 40'hFF_FF_FF_FF_FF);
    write_reg(REG_KROW4, 40'hFF_FF_FF_FF_FF);
    set_frame(4, 3);
    for (int r = 0; r < 3 + HK; r++)
      for (int c = 0; c < 4; c++)
        pending_items.push_back('{cmd: (r >= 3) ^ (c == 2 && r == 1),
                                  pixel: (c[0] ^ r[0]) ? 8'hFF : 8'h00});
    wait_idle();

    // Zero positive sum: no results, stream still advances.
    write_reg(REG_KROW0, 40'h0);
    write_reg(REG_KROW1, 40'h80_80_80);
    write_reg(REG_KROW2, 40'h0);
    set_frame(1, 1);
    queue_frames(1, 1, 2, 1'b0);
    wait_idle();

    // Random: varied kernels and small frames, the smallest frame and a single tall column
    // included.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_KROW0, rand_krow());
      write_reg(REG_KROW1, rand_krow());
      write_reg(REG_KROW2, ($urandom_range(0, 1)) ? rand_krow() : 40'h01_02_01);
      if (ph == 3) begin
        w = 1; h = 1;
      end else if (ph == 5) begin
        w = 1; h = 6;
      end else begin
        w = $urandom_range(1, 5); h = $urandom_range(1, 3);
      end
      set_frame(w, h);
      if (ph == 7) begin
        // Long receiver hold-off while the sender keeps offering requests.
        queue_frames(w, h, 2, 1'b1);
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (ph >= 10) quiet_tail = 1'b1;
        queue_frames(w, h, 1, (ph % 2) == 1);
      end
      wait_idle();
    end
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule
